// ===== sv/dbsed_pkg.sv =====
package dbsed_pkg;

   // Counter width of the event counters
   localparam int COUNTER_WIDTH = 32;

   // Fixed field widths
   localparam int SNAP_W  = 26;
   localparam int ADDR_W  = 13;
   localparam int DATA_W  = 8;
   localparam int OUT_CNT_W = 32;

   // Peripheral decode constants
   localparam logic [ADDR_W-1:0] HOME_ADDR    = 13'h0022;
   localparam logic [3:0]        REG_SEL_MASK = 4'hF;
   localparam int                SEL_HIGH_PIN = 24;
   localparam int                SEL_LOW_PIN  = 25;
   localparam logic [DATA_W-1:0] HOME_DATA    = 8'h01;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Result kinds
   typedef enum logic [1:0] {
      KIND_MOTOR = 2'd0,
      KIND_PHASE = 2'd1,
      KIND_HOME  = 2'd2
   } kind_type;

   // One classified write, carrying everything its results need
   typedef struct packed {
      logic                 motor_ev;
      logic                 phase_ev;
      logic                 home_ev;
      logic                 motor;
      logic [1:0]           old_phase;
      logic [1:0]           new_phase;
      logic [DATA_W-1:0]    data;
      logic [OUT_CNT_W-1:0] motor_pcount;
      logic [OUT_CNT_W-1:0] phase_pcount;
      logic [OUT_CNT_W-1:0] hcount;
   } job_type;

endpackage

// ===== sv/dbsed_front.sv =====
module dbsed_front
   import dbsed_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [SNAP_W-1:0] req_snapshot,
   output logic              req_full,
   input  logic              q_full,
   output logic              q_push,
   output job_type           q_job
);

   logic                     motor_seen_ff, motor_seen_in;
   logic                     prev_motor_ff, prev_motor_in;
   logic                     phase_seen_ff, phase_seen_in;
   logic [1:0]               prev_phase_ff, prev_phase_in;
   logic [COUNTER_WIDTH-1:0] pcount_ff, pcount_in;
   logic [COUNTER_WIDTH-1:0] hcount_ff, hcount_in;

   logic              accept;
   logic [ADDR_W-1:0] addr;
   logic [DATA_W-1:0] data;
   logic              selected;
   logic              port_wr;
   logic              home_wr;
   logic              motor;
   logic [1:0]        phase;
   logic              motor_ev;
   logic              phase_ev;

   assign req_full = q_full;
   assign accept   = req_push & ~q_full;

   // Unscramble pins into address and data
   always_comb begin
      for (int i = 0; i < 11; i++) begin
         addr[i] = req_snapshot[23 - i];
      end
      addr[11] = req_snapshot[11];
      addr[12] = req_snapshot[12];
      data = {req_snapshot[4], req_snapshot[3], req_snapshot[2], req_snapshot[1],
              req_snapshot[0], req_snapshot[5], req_snapshot[6], req_snapshot[7]};
   end

   // Classify the write
   assign selected = req_snapshot[SEL_HIGH_PIN] & ~req_snapshot[SEL_LOW_PIN];
   assign port_wr  = selected & ((addr[3:0] & REG_SEL_MASK) == 4'd0);
   assign home_wr  = ~selected & (addr == HOME_ADDR) & (data == HOME_DATA);
   assign motor    = data[2];
   assign phase    = data[1:0];
   assign motor_ev = port_wr & (~motor_seen_ff | (motor != prev_motor_ff));
   assign phase_ev = port_wr & phase_seen_ff & (phase != prev_phase_ff);

   // Next state of the tracking registers
   always_comb begin
      motor_seen_in = motor_seen_ff;
      prev_motor_in = prev_motor_ff;
      phase_seen_in = phase_seen_ff;
      prev_phase_in = prev_phase_ff;
      pcount_in     = pcount_ff;
      hcount_in     = hcount_ff;
      if (accept && port_wr) begin
         motor_seen_in = 1'b1;
         prev_motor_in = motor;
         phase_seen_in = 1'b1;
         prev_phase_in = phase;
      end
      if (accept && phase_ev) begin
         pcount_in = pcount_ff + COUNTER_WIDTH'(1);
      end
      if (accept && home_wr) begin
         hcount_in = hcount_ff + COUNTER_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motor_seen_ff <= 1'b0;
         prev_motor_ff <= 1'b0;
         phase_seen_ff <= 1'b0;
         prev_phase_ff <= 2'd0;
         pcount_ff     <= '0;
         hcount_ff     <= '0;
      end else begin
         motor_seen_ff <= motor_seen_in;
         prev_motor_ff <= prev_motor_in;
         phase_seen_ff <= phase_seen_in;
         prev_phase_ff <= prev_phase_in;
         pcount_ff     <= pcount_in;
         hcount_ff     <= hcount_in;
      end
   end

   // Build the job; drop writes that cause no result
   assign q_push = accept & (motor_ev | phase_ev | home_wr);

   always_comb begin
      q_job.motor_ev     = motor_ev;
      q_job.phase_ev     = phase_ev;
      q_job.home_ev      = home_wr;
      q_job.motor        = motor;
      q_job.old_phase    = prev_phase_ff;
      q_job.new_phase    = phase;
      q_job.data         = data;
      q_job.motor_pcount = OUT_CNT_W'(pcount_ff);
      q_job.phase_pcount = OUT_CNT_W'(pcount_in);
      q_job.hcount       = OUT_CNT_W'(hcount_in);
   end

endmodule

// ===== sv/dbsed_queue.sv =====
module dbsed_queue
   import dbsed_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_push,
   input  job_type wr_job,
   output logic    wr_full,
   output logic    rd_valid,
   input  logic    rd_pop,
   output job_type rd_job
);

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   head_ff, head_in;
   logic [QPTR_W-1:0]   tail_ff, tail_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_wr;
   logic                do_rd;

   assign wr_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_job   = mem_ff[head_ff];
   assign do_wr    = wr_push & ~wr_full;
   assign do_rd    = rd_pop & rd_valid;

   // Advance pointers and occupancy
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_wr) begin
         tail_in = (tail_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + QPTR_W'(1);
      end
      if (do_rd) begin
         head_in = (head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[tail_ff] <= wr_job;
      end
   end

endmodule

// ===== sv/dbsed_back.sv =====
module dbsed_back
   import dbsed_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  job_type              q_job,
   output logic                 q_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [1:0]           rsp_event_kind,
   output logic                 rsp_motor_state,
   output logic [1:0]           rsp_old_phase,
   output logic [1:0]           rsp_new_phase,
   output logic [1:0]           rsp_step_delta,
   output logic [DATA_W-1:0]    rsp_data_byte,
   output logic [OUT_CNT_W-1:0] rsp_phase_changes,
   output logic [OUT_CNT_W-1:0] rsp_home_writes,
   output logic                 rsp_last
);

   logic                 valid_ff, valid_in;
   logic                 second_ff, second_in;
   kind_type             kind_ff, kind_in;
   logic                 motor_ff, motor_in;
   logic [1:0]           oldp_ff, oldp_in;
   logic [1:0]           newp_ff, newp_in;
   logic [1:0]           delta_ff, delta_in;
   logic [DATA_W-1:0]    data_ff, data_in;
   logic [OUT_CNT_W-1:0] pcount_ff, pcount_in;
   logic [OUT_CNT_W-1:0] hcount_ff, hcount_in;
   logic                 last_ff, last_in;
   logic                 load;
   logic                 split;
   logic                 do_phase;

   // Load the output register when it is free or being drained
   assign load     = q_valid & (~valid_ff | rsp_pop);
   assign split    = q_job.motor_ev & q_job.phase_ev & ~second_ff;
   assign do_phase = second_ff | (q_job.phase_ev & ~q_job.motor_ev);
   assign q_pop    = load & ~split;

   always_comb begin
      valid_in  = valid_ff & ~rsp_pop;
      second_in = second_ff;
      kind_in   = kind_ff;
      motor_in  = motor_ff;
      oldp_in   = oldp_ff;
      newp_in   = newp_ff;
      delta_in  = delta_ff;
      data_in   = data_ff;
      pcount_in = pcount_ff;
      hcount_in = hcount_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in  = 1'b1;
         second_in = split;
         last_in   = ~split;
         data_in   = q_job.data;
         hcount_in = q_job.hcount;
         if (do_phase) begin
            kind_in   = KIND_PHASE;
            motor_in  = q_job.motor;
            oldp_in   = q_job.old_phase;
            newp_in   = q_job.new_phase;
            delta_in  = q_job.new_phase - q_job.old_phase;
            pcount_in = q_job.phase_pcount;
         end else if (q_job.motor_ev) begin
            kind_in   = KIND_MOTOR;
            motor_in  = q_job.motor;
            oldp_in   = 2'd0;
            newp_in   = 2'd0;
            delta_in  = 2'd0;
            pcount_in = q_job.motor_pcount;
         end else begin
            kind_in   = KIND_HOME;
            motor_in  = 1'b0;
            oldp_in   = 2'd0;
            newp_in   = 2'd0;
            delta_in  = 2'd0;
            pcount_in = q_job.phase_pcount;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      motor_ff  <= motor_in;
      oldp_ff   <= oldp_in;
      newp_ff   <= newp_in;
      delta_ff  <= delta_in;
      data_ff   <= data_in;
      pcount_ff <= pcount_in;
      hcount_ff <= hcount_in;
      last_ff   <= last_in;
   end

   assign rsp_empty         = ~valid_ff;
   assign rsp_event_kind    = kind_ff;
   assign rsp_motor_state   = motor_ff;
   assign rsp_old_phase     = oldp_ff;
   assign rsp_new_phase     = newp_ff;
   assign rsp_step_delta    = delta_ff;
   assign rsp_data_byte     = data_ff;
   assign rsp_phase_changes = pcount_ff;
   assign rsp_home_writes   = hcount_ff;
   assign rsp_last          = last_ff;

endmodule

// ===== sv/drive_bus_snoop_event_decoder.sv =====
// Bus write snoop event decoder.
// Input channel: one 26-pin bus write snapshot per transfer (req_push/req_full).
// Result channel: queue-style (rsp_empty/rsp_pop); the head result sits on the
// rsp_ ports while rsp_empty is low. A snapshot causes zero, one or two results;
// rsp_last marks the final result of a snapshot.
// The front decodes and classifies a snapshot in the cycle it is taken and
// updates the motor, phase and counter state at once; writes that cause no
// result are dropped there. Jobs cross a 4-entry queue to the back, which
// issues one result per cycle into an output register that is free or popped.
// Path: a result reaches the rsp_ ports through the queue entry, then the
// output register, when the path is clear. Throughput: one snapshot per cycle
// while the queue is not full; a snapshot that gives both a motor and a phase
// result loads the output register twice, the motor result first.
// When the receiver stalls, the output register holds, the queue fills, and
// req_full rises once the queue is full; nothing is lost.
// Reset (synchronous) clears the tracking state, both counters, the queue and
// the output register; the block takes snapshots the cycle after reset.
module drive_bus_snoop_event_decoder
   import dbsed_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [SNAP_W-1:0]    req_snapshot,
   output logic                 req_full,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [1:0]           rsp_event_kind,
   output logic                 rsp_motor_state,
   output logic [1:0]           rsp_old_phase,
   output logic [1:0]           rsp_new_phase,
   output logic [1:0]           rsp_step_delta,
   output logic [DATA_W-1:0]    rsp_data_byte,
   output logic [OUT_CNT_W-1:0] rsp_phase_changes,
   output logic [OUT_CNT_W-1:0] rsp_home_writes,
   output logic                 rsp_last
);

   logic    q_full;
   logic    q_push;
   job_type q_wr_job;
   logic    q_valid;
   logic    q_pop;
   job_type q_rd_job;

   dbsed_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_snapshot (req_snapshot),
      .req_full     (req_full),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_job        (q_wr_job)
   );

   dbsed_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (q_push),
      .wr_job   (q_wr_job),
      .wr_full  (q_full),
      .rd_valid (q_valid),
      .rd_pop   (q_pop),
      .rd_job   (q_rd_job)
   );

   dbsed_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_job             (q_rd_job),
      .q_pop             (q_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_motor_state   (rsp_motor_state),
      .rsp_old_phase     (rsp_old_phase),
      .rsp_new_phase     (rsp_new_phase),
      .rsp_step_delta    (rsp_step_delta),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_phase_changes (rsp_phase_changes),
      .rsp_home_writes   (rsp_home_writes),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== tb/sv/tb_drive_bus_snoop_event_decoder.sv =====
`timescale 1ns / 1ps

module tb_drive_bus_snoop_event_decoder;
   import dbsed_pkg::*;

   localparam int RESET_CYCLES     = 12;
   localparam int RANDOM_ITEMS     = 570;
   localparam int STEADY_ITEMS     = 80;
   localparam int MIDWAY_ITEMS     = 300;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int FULL_HOLD_CYCLES = 20;
   localparam int MOTOR_BIT        = 2;
   localparam logic [ADDR_W-1:0] PORT_REG = '0;

   // One expected result transfer
   typedef struct packed {
      kind_type             kind;
      logic                 motor;
      logic [1:0]           old_phase;
      logic [1:0]           new_phase;
      logic [1:0]           step_delta;
      logic [DATA_W-1:0]    data;
      logic [OUT_CNT_W-1:0] phase_changes;
      logic [OUT_CNT_W-1:0] home_writes;
      logic                 last;
   } bus_event_type;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_push     = 1'b0;
   logic [SNAP_W-1:0]    req_snapshot = '0;
   logic                 req_full;
   logic                 rsp_pop      = 1'b0;
   logic                 rsp_empty;
   logic [1:0]           rsp_event_kind;
   logic                 rsp_motor_state;
   logic [1:0]           rsp_old_phase;
   logic [1:0]           rsp_new_phase;
   logic [1:0]           rsp_step_delta;
   logic [DATA_W-1:0]    rsp_data_byte;
   logic [OUT_CNT_W-1:0] rsp_phase_changes;
   logic [OUT_CNT_W-1:0] rsp_home_writes;
   logic                 rsp_last;

   // Tracked decoder state, same reset values as the block
   logic                     motor_known = 1'b0;
   logic                     motor_on    = 1'b0;
   logic                     phase_known = 1'b0;
   logic [1:0]               phase_now   = 2'b00;
   logic [COUNTER_WIDTH-1:0] phase_change_total = '0;
   logic [COUNTER_WIDTH-1:0] home_total         = '0;

   bus_event_type pending_bus_events[$];
   int            mismatch_count = 0;
   int            quiet_cycles   = 0;

   // Flow control knobs
   bit req_steady    = 1'b0;
   bit rsp_steady    = 1'b0;
   bit rsp_hold      = 1'b0;
   int rsp_stall_left = 0;

   drive_bus_snoop_event_decoder dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      else if (roll < 85) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 40);
   endfunction

   // Scramble an address and data byte onto the bus pins
   function automatic logic [SNAP_W-1:0] bus_write(input logic [ADDR_W-1:0] addr,
                                                   input logic [DATA_W-1:0] data,
                                                   input logic sel_high,
                                                   input logic sel_low,
                                                   input logic [2:0] spare);
      logic [SNAP_W-1:0] snap;
      snap = '0;
      for (int i = 0; i < 11; i++) snap[23 - i] = addr[i];
      snap[11] = addr[11];
      snap[12] = addr[12];
      {snap[4], snap[3], snap[2], snap[1], snap[0], snap[5], snap[6], snap[7]} = data;
      snap[10:8] = spare;
      snap[SEL_HIGH_PIN] = sel_high;
      snap[SEL_LOW_PIN]  = sel_low;
      return snap;
   endfunction

   // Decode one snapshot, advance the tracked state, queue its events
   function automatic int decode_bus_write(input logic [SNAP_W-1:0] snap);
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic              selected;
      bus_event_type     batch[2];
      int                count;
      count = 0;
      addr = {snap[12], snap[11], snap[13], snap[14], snap[15], snap[16], snap[17],
              snap[18], snap[19], snap[20], snap[21], snap[22], snap[23]};
      data = {snap[4], snap[3], snap[2], snap[1], snap[0], snap[5], snap[6], snap[7]};
      selected = snap[SEL_HIGH_PIN] && !snap[SEL_LOW_PIN];
      batch[0] = '0;
      batch[1] = '0;
      if (selected && (addr[3:0] & REG_SEL_MASK) == 4'h0) begin
         // Motor: report first sighting and every change
         if (!motor_known || data[MOTOR_BIT] != motor_on) begin
            motor_known = 1'b1;
            motor_on    = data[MOTOR_BIT];
            batch[count].kind          = KIND_MOTOR;
            batch[count].motor         = data[MOTOR_BIT];
            batch[count].data          = data;
            batch[count].phase_changes = phase_change_total[OUT_CNT_W-1:0];
            batch[count].home_writes   = home_total[OUT_CNT_W-1:0];
            count++;
         end
         // Phase: record first sighting silently, report later changes
         if (!phase_known) begin
            phase_known = 1'b1;
            phase_now   = data[1:0];
         end else if (data[1:0] != phase_now) begin
            phase_change_total++;
            batch[count].kind          = KIND_PHASE;
            batch[count].motor         = data[MOTOR_BIT];
            batch[count].old_phase     = phase_now;
            batch[count].new_phase     = data[1:0];
            batch[count].step_delta    = data[1:0] - phase_now;
            batch[count].data          = data;
            batch[count].phase_changes = phase_change_total[OUT_CNT_W-1:0];
            batch[count].home_writes   = home_total[OUT_CNT_W-1:0];
            phase_now = data[1:0];
            count++;
         end
      end else if (!selected && addr == HOME_ADDR && data == HOME_DATA) begin
         home_total++;
         batch[0].kind          = KIND_HOME;
         batch[0].data          = data;
         batch[0].phase_changes = phase_change_total[OUT_CNT_W-1:0];
         batch[0].home_writes   = home_total[OUT_CNT_W-1:0];
         count = 1;
      end
      if (count > 0) batch[count - 1].last = 1'b1;
      for (int i = 0; i < count; i++) pending_bus_events.push_back(batch[i]);
      return count;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   // Offer one snapshot, hold it until the transfer, then maybe idle
   task automatic send_bus_write(input logic [SNAP_W-1:0] snap, output int produced);
      int gap;
      req_push     <= 1'b1;
      req_snapshot <= snap;
      do @(posedge clock); while (req_full);
      produced = decode_bus_write(snap);
      gap = req_steady ? 0 : idle_length();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and let every expected result drain out
   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_bus_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random snapshot, weighted toward port and home writes
   function automatic logic [SNAP_W-1:0] random_bus_write();
      int                roll;
      logic [ADDR_W-1:0] addr;
      logic [1:0]        unsel;
      roll  = $urandom_range(0, 99);
      addr  = ADDR_W'($urandom);
      unsel = ($urandom_range(0, 2) == 0) ? 2'b00 : ($urandom_range(0, 1) ? 2'b01 : 2'b11);
      if (roll < 50)
         return bus_write({addr[ADDR_W-1:4], 4'h0}, DATA_W'($urandom), 1'b1, 1'b0,
                          3'($urandom));
      else if (roll < 65)
         return bus_write(HOME_ADDR, HOME_DATA, unsel[1], unsel[0], 3'($urandom));
      else if (roll < 72)
         return bus_write(HOME_ADDR ^ (ADDR_W'(1) << $urandom_range(0, ADDR_W - 1)),
                          HOME_DATA, unsel[1], unsel[0], 3'($urandom));
      else if (roll < 78)
         return bus_write(HOME_ADDR, DATA_W'($urandom_range(0, 3)), unsel[1], unsel[0],
                          3'($urandom));
      else if (roll < 84)
         return bus_write({addr[ADDR_W-1:4], 4'($urandom_range(1, 15))}, DATA_W'($urandom),
                          1'b1, 1'b0, 3'($urandom));
      else
         return SNAP_W'($urandom);
   endfunction

   task automatic test_port_byte_events();
      int n;
      // first port byte: motor reported, phase taken silently
      send_bus_write(bus_write(PORT_REG, 8'h00, 1'b1, 1'b0, 3'b000), n);
      send_bus_write(bus_write(PORT_REG, 8'h00, 1'b1, 1'b0, 3'b000), n);
      send_bus_write(bus_write(PORT_REG, 8'h01, 1'b1, 1'b0, 3'b000), n);
      send_bus_write(bus_write(PORT_REG, 8'h05, 1'b1, 1'b0, 3'b000), n);
      send_bus_write(bus_write(PORT_REG, 8'h07, 1'b1, 1'b0, 3'b000), n);
      // motor and phase change together: motor result first
      send_bus_write(bus_write(PORT_REG, 8'h00, 1'b1, 1'b0, 3'b000), n);
      send_bus_write(bus_write(13'h1FF0, 8'hFA, 1'b1, 1'b0, 3'b000), n);
      send_bus_write(bus_write(13'h0AA0, 8'hFF, 1'b1, 1'b0, 3'b111), n);
      send_bus_write(bus_write(13'h1550, 8'hFE, 1'b1, 1'b0, 3'b010), n);
   endtask

   task automatic test_ignored_writes();
      int n;
      send_bus_write(bus_write(13'h0001, 8'h03, 1'b1, 1'b0, 3'b000), n);
      send_bus_write(bus_write(13'h0008, 8'h04, 1'b1, 1'b0, 3'b000), n);
      send_bus_write('0, n);
      send_bus_write('1, n);
      // both select pins high counts as unselected
      send_bus_write(bus_write(PORT_REG, 8'h00, 1'b1, 1'b1, 3'b000), n);
   endtask

   task automatic test_home_writes();
      int n;
      send_bus_write(bus_write(HOME_ADDR, HOME_DATA, 1'b0, 1'b0, 3'b000), n);
      send_bus_write(bus_write(HOME_ADDR, HOME_DATA, 1'b1, 1'b1, 3'b101), n);
      send_bus_write(bus_write(HOME_ADDR, HOME_DATA, 1'b0, 1'b1, 3'b111), n);
      send_bus_write(bus_write(HOME_ADDR, 8'h00, 1'b0, 1'b0, 3'b000), n);
      send_bus_write(bus_write(HOME_ADDR, 8'h03, 1'b0, 1'b0, 3'b000), n);
      send_bus_write(bus_write(13'h0023, HOME_DATA, 1'b0, 1'b0, 3'b000), n);
      send_bus_write(bus_write(13'h1022, HOME_DATA, 1'b0, 1'b0, 3'b000), n);
      // selected write to the home address is a non-port register
      send_bus_write(bus_write(HOME_ADDR, HOME_DATA, 1'b1, 1'b0, 3'b000), n);
   endtask

   // Hold the receiver until the block reports full, with two results per write
   task automatic test_backpressure();
      int         n;
      logic [4:0] upper;
      rsp_hold <= 1'b1;
      fork
         begin
            do @(posedge clock); while (!req_full);
            repeat (FULL_HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      req_steady = 1'b1;
      for (int i = 0; i < 8; i++) begin
         upper = 5'($urandom);
         send_bus_write(bus_write(PORT_REG, {upper, i[0], i[1:0]}, 1'b1, 1'b0, 3'($urandom)),
                        n);
      end
      req_steady = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int produced;
      int sent;
      bit drained_midway;
      sent           = 0;
      drained_midway = 1'b0;
      // open with a stretch of back-to-back transfers on both sides
      req_steady = 1'b1;
      rsp_steady <= 1'b1;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= STEADY_ITEMS && req_steady) begin
            req_steady = 1'b0;
            rsp_steady <= 1'b0;
         end
         if (sent >= MIDWAY_ITEMS && !drained_midway) begin
            drained_midway = 1'b1;
            wait_drained();
         end
         send_bus_write(random_bus_write(), produced);
         sent++;
      end
   endtask

   // Receiver: pop with random stalls unless held or steady
   always @(posedge clock) begin
      if (rsp_hold || rsp_stall_left > 0) begin
         rsp_pop <= 1'b0;
         if (rsp_stall_left > 0) rsp_stall_left <= rsp_stall_left - 1;
      end else begin
         rsp_pop <= 1'b1;
         if (!rsp_steady && $urandom_range(0, 3) == 0) rsp_stall_left <= idle_length();
      end
   end

   // Compare each result transfer with the oldest expected event
   always @(posedge clock) begin : check_results
      bus_event_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_bus_events.size() == 0) begin
            $error("rsp: unexpected transfer, event_kind 0x%0h", rsp_event_kind);
            mismatch_count++;
         end else begin
            want = pending_bus_events.pop_front();
            check_field("event_kind", want.kind, rsp_event_kind);
            check_field("motor_state", want.motor, rsp_motor_state);
            check_field("old_phase", want.old_phase, rsp_old_phase);
            check_field("new_phase", want.new_phase, rsp_new_phase);
            check_field("step_delta", want.step_delta, rsp_step_delta);
            check_field("data_byte", want.data, rsp_data_byte);
            check_field("phase_changes", want.phase_changes, rsp_phase_changes);
            check_field("home_writes", want.home_writes, rsp_home_writes);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_port_byte_events();
      test_ignored_writes();
      test_home_writes();
      wait_drained();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
